@@ sv/lhd_pkg.sv @@
// Shared widths, register indexes, rate codes and syndrome codes for the Hamming decoder.
package lhd_pkg;

  // Field and register widths.
  localparam int CW_W    = 8;
  localparam int NIB_W   = 4;
  localparam int RATE_W  = 3;
  localparam int SF_W    = 4;
  localparam int IDX_W   = 4;
  localparam int CFG_A_W = 1;
  localparam int CFG_D_W = 4;
  localparam int TDATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] REG_CODING_RATE      = 1'b0;
  localparam logic [CFG_A_W-1:0] REG_SPREADING_FACTOR = 1'b1;

  // Register reset values.
  localparam logic [RATE_W-1:0] CODING_RATE_RST      = 3'd4;
  localparam logic [SF_W-1:0]   SPREADING_FACTOR_RST = 4'd7;

  // Applied coding rates (parity bits per codeword).
  localparam logic [RATE_W-1:0] RATE_4_5 = 3'd1;
  localparam logic [RATE_W-1:0] RATE_4_6 = 3'd2;
  localparam logic [RATE_W-1:0] RATE_4_7 = 3'd3;
  localparam logic [RATE_W-1:0] RATE_4_8 = 3'd4;

  // Number of codewords by which the header is shorter than the spreading factor.
  localparam logic [SF_W:0] HDR_OFFSET = 5'd2;

  // Saturation value of the codeword position counter.
  localparam logic [IDX_W-1:0] IDX_MAX = 4'd15;

  // Syndrome codes that point at a data bit.
  localparam logic [2:0] SYN_FLIP_D0 = 3'd5;
  localparam logic [2:0] SYN_FLIP_D1 = 3'd7;
  localparam logic [2:0] SYN_FLIP_D2 = 3'd3;
  localparam logic [2:0] SYN_FLIP_D3 = 3'd6;

endpackage

@@ sv/lhd_frame_ctrl.sv @@
// Configuration registers, frame position counter and applied coding rate selection.
module lhd_frame_ctrl
  import lhd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CFG_A_W-1:0]  cfg_index,
  input  logic [CFG_D_W-1:0]  cfg_data,
  input  logic                accept,
  input  logic                frame_start,
  output logic [RATE_W-1:0]   rate
);

  logic [RATE_W-1:0] coding_rate;
  logic [SF_W-1:0]   spreading_factor;
  logic [IDX_W-1:0]  codeword_index;
  logic [IDX_W-1:0]  codeword_index_next;
  logic [IDX_W-1:0]  pos;
  logic              in_header;
  logic [RATE_W-1:0] rate_clamped;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      coding_rate      <= CODING_RATE_RST;
      spreading_factor <= SPREADING_FACTOR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CODING_RATE:      coding_rate      <= cfg_data[RATE_W-1:0];
        REG_SPREADING_FACTOR: spreading_factor <= cfg_data[SF_W-1:0];
        default: ;
      endcase
    end
  end

  // Position of the current codeword; a frame start puts it at zero.
  assign pos = frame_start ? '0 : codeword_index;
  assign codeword_index_next = (pos < IDX_MAX) ? pos + 1'b1 : IDX_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      codeword_index <= '0;
    end else if (accept) begin
      codeword_index <= codeword_index_next;
    end
  end

  // The header holds spreading_factor minus two codewords, none if that is negative.
  assign in_header = ({1'b0, pos} + HDR_OFFSET) < {1'b0, spreading_factor};

  // Out-of-range rates fold onto the nearest valid rate.
  always_comb begin
    if (coding_rate < RATE_4_5) begin
      rate_clamped = RATE_4_5;
    end else if (coding_rate > RATE_4_8) begin
      rate_clamped = RATE_4_8;
    end else begin
      rate_clamped = coding_rate;
    end
  end

  assign rate = in_header ? RATE_4_8 : rate_clamped;

endmodule

@@ sv/lhd_decode.sv @@
// Hamming data extraction and single-bit correction for one codeword.
module lhd_decode
  import lhd_pkg::*;
(
  input  logic [CW_W-1:0]   codeword,
  input  logic [RATE_W-1:0] rate,
  output logic [NIB_W-1:0]  nibble
);

  logic [NIB_W-1:0] data;
  logic [2:0]       parity;
  logic [2:0]       syn;
  logic             fix;

  // Pick data and parity bits; the first data bit is the top used bit.
  always_comb begin
    unique case (rate)
      RATE_4_5: begin
        data   = {codeword[1], codeword[2], codeword[3], codeword[4]};
        parity = '0;
      end
      RATE_4_6: begin
        data   = {codeword[2], codeword[3], codeword[4], codeword[5]};
        parity = '0;
      end
      RATE_4_7: begin
        data   = {codeword[3], codeword[4], codeword[5], codeword[6]};
        parity = {codeword[0], codeword[1], codeword[2]};
      end
      default: begin
        data   = {codeword[4], codeword[5], codeword[6], codeword[7]};
        parity = {codeword[1], codeword[2], codeword[3]};
      end
    endcase
  end

  // Correction runs at 4/7 always and at 4/8 only when total parity is odd.
  assign fix = (rate == RATE_4_7) || ((rate == RATE_4_8) && (^codeword));

  assign syn[0] = data[0] ^ data[1] ^ data[2] ^ parity[0];
  assign syn[1] = data[1] ^ data[2] ^ data[3] ^ parity[1];
  assign syn[2] = data[0] ^ data[1] ^ data[3] ^ parity[2];

  // Flip the data bit that the syndrome points at.
  always_comb begin
    nibble = data;
    if (fix) begin
      unique case (syn)
        SYN_FLIP_D0: nibble[0] = ~data[0];
        SYN_FLIP_D1: nibble[1] = ~data[1];
        SYN_FLIP_D2: nibble[2] = ~data[2];
        SYN_FLIP_D3: nibble[3] = ~data[3];
        default:     nibble    = data;
      endcase
    end
  end

endmodule

@@ sv/lora_hamming_decoder.sv @@
// Path: an input transfer loads the codeword register; the decoded nibble is then
// loaded into the result register, which drives the output stream.
// Throughput: one codeword per cycle while m_tready stays high; each register
// loads when the stage after it is empty or emptying.
// Reset: synchronous, active high; clears the pipeline valids and the frame
// position counter and restores coding rate 4/8 and spreading factor 7.
module lora_hamming_decoder
  import lhd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Configuration write port.
  input  logic                cfg_wr_en,
  input  logic [CFG_A_W-1:0]  cfg_index,
  input  logic [CFG_D_W-1:0]  cfg_data,
  // Input stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [TDATA_W-1:0]  s_tdata,   // [7:0] codeword
  input  logic                s_tuser,   // [0] frame_start
  // Output stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [TDATA_W-1:0]  m_tdata    // [3:0] nibble, [7:4] zero
);

  logic              s_accept;
  logic              s1_ready;
  logic              s1_valid;
  logic [CW_W-1:0]   s1_codeword;
  logic [RATE_W-1:0] s1_rate;
  logic [RATE_W-1:0] rate;
  logic [NIB_W-1:0]  dec_nibble;
  logic [NIB_W-1:0]  m_nibble;

  // Each stage moves on when the stage after it is empty or emptying.
  assign s1_ready = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_ready;
  assign s_accept = s_tvalid && s_tready;

  lhd_frame_ctrl u_frame_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (s_accept),
    .frame_start (s_tuser),
    .rate        (rate)
  );

  // Codeword register with its applied rate.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_codeword <= s_tdata[CW_W-1:0];
      s1_rate     <= rate;
    end
  end

  lhd_decode u_decode (
    .codeword (s1_codeword),
    .rate     (s1_rate),
    .nibble   (dec_nibble)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_ready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      m_nibble <= dec_nibble;
    end
  end

  assign m_tdata = {{(TDATA_W-NIB_W){1'b0}}, m_nibble};

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the LoRa Hamming decoder: directed table, then random frames.
module tb_top;
  import lhd_pkg::*;

  // Coding rate and spreading factor as written to the configuration port.
  typedef struct packed {
    logic [CFG_D_W-1:0] rate;
    logic [CFG_D_W-1:0] sf;
  } decoder_settings_t;

  // One directed codeword; the nibble is only used where known is set.
  typedef struct packed {
    decoder_settings_t settings;
    logic [CW_W-1:0]   cw;
    logic              fs;
    logic              known;
    logic [NIB_W-1:0]  nibble;
  } directed_row_t;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned PIPE_DRAIN      = 4;
  localparam int unsigned ITEMS_PER_PHASE = 52;
  localparam int unsigned NUM_ROWS        = 25;
  localparam int unsigned NUM_PHASES      = 12;

  // Header cases at 4/8, then 4/7, 4/6, 4/5, rates out of range, tiny spreading
  // factors, and a short header at spreading factor 5 with a frame restart.
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{'{4'd4, 4'd7}, 8'h00, 1'b1, 1'b1, 4'h0},
    '{'{4'd4, 4'd7}, 8'hFF, 1'b0, 1'b1, 4'hF},
    '{'{4'd4, 4'd7}, 8'h80, 1'b0, 1'b1, 4'h0},
    '{'{4'd4, 4'd7}, 8'h40, 1'b0, 1'b1, 4'h0},
    '{'{4'd4, 4'd7}, 8'h20, 1'b0, 1'b1, 4'h0},
    '{'{4'd4, 4'd7}, 8'h10, 1'b0, 1'b1, 4'h0},
    '{'{4'd4, 4'd7}, 8'h08, 1'b0, 1'b1, 4'h0},
    '{'{4'd4, 4'd7}, 8'h01, 1'b0, 1'b1, 4'h0},
    '{'{4'd4, 4'd7}, 8'hC0, 1'b0, 1'b1, 4'h3},
    '{'{4'd4, 4'd7}, 8'hA5, 1'b0, 1'b0, 4'h0},
    '{'{4'd3, 4'd2}, 8'h40, 1'b1, 1'b1, 4'h0},
    '{'{4'd3, 4'd2}, 8'h7F, 1'b0, 1'b1, 4'hF},
    '{'{4'd3, 4'd2}, 8'h80, 1'b0, 1'b1, 4'h0},
    '{'{4'd3, 4'd2}, 8'h5A, 1'b0, 1'b0, 4'h0},
    '{'{4'd2, 4'd2}, 8'h3C, 1'b0, 1'b1, 4'hF},
    '{'{4'd2, 4'd2}, 8'hC3, 1'b0, 1'b0, 4'h0},
    '{'{4'd1, 4'd2}, 8'hE0, 1'b0, 1'b1, 4'h0},
    '{'{4'd0, 4'd2}, 8'h1E, 1'b0, 1'b1, 4'hF},
    '{'{4'd7, 4'd2}, 8'h80, 1'b0, 1'b1, 4'h0},
    '{'{4'd1, 4'd0}, 8'h10, 1'b1, 1'b1, 4'h1},
    '{'{4'd2, 4'd1}, 8'h20, 1'b0, 1'b1, 4'h1},
    '{'{4'd1, 4'd5}, 8'h08, 1'b1, 1'b1, 4'h0},
    '{'{4'd1, 4'd5}, 8'h08, 1'b0, 1'b1, 4'h0},
    '{'{4'd1, 4'd5}, 8'h08, 1'b0, 1'b1, 4'h0},
    '{'{4'd1, 4'd5}, 8'h08, 1'b0, 1'b1, 4'h2}
  };

  // Settings for the random phases; rate values above 7 exercise the unused data bit.
  localparam decoder_settings_t RANDOM_PHASES [NUM_PHASES] = '{
    '{4'd1, 4'd12}, '{4'd2, 4'd5}, '{4'd3, 4'd12}, '{4'd4, 4'd5},
    '{4'd0, 4'd15}, '{4'd5, 4'd0}, '{4'd7, 4'd2}, '{4'd3, 4'd1},
    '{4'd4, 4'd12}, '{4'd2, 4'd9}, '{4'd12, 4'd6}, '{4'd11, 4'd8}
  };

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [CFG_A_W-1:0]  cfg_index;
  logic [CFG_D_W-1:0]  cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata;   // [7:0] codeword
  logic                s_tuser;   // [0] frame_start
  logic                m_tvalid;
  logic                m_tready;
  logic [TDATA_W-1:0]  m_tdata;   // [3:0] nibble, [7:4] zero

  // Decoder state as the testbench sees it.
  logic [RATE_W-1:0]   rate_cfg;
  logic [SF_W-1:0]     sf_cfg;
  logic [IDX_W-1:0]    frame_pos;
  decoder_settings_t   active_settings;

  logic [NIB_W-1:0]    expected_nibbles [$];
  logic [NIB_W-1:0]    want_nibble;
  int unsigned         mismatch_count;
  int unsigned         idle_cycles;

  lora_hamming_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Decodes one codeword against the current settings and advances the frame position.
  function automatic logic [NIB_W-1:0] decode_codeword(input logic [CW_W-1:0] cw,
                                                       input logic fs);
    logic [IDX_W-1:0]  pos;
    logic [SF_W-1:0]   hdr_len;
    logic [RATE_W-1:0] rate;
    int                width;
    logic [3:0]        d;
    logic [2:0]        p;
    logic [2:0]        syn;
    pos = fs ? '0 : frame_pos;
    hdr_len = (sf_cfg >= HDR_OFFSET) ? sf_cfg - HDR_OFFSET[SF_W-1:0] : '0;
    rate = rate_cfg;
    if (rate < RATE_4_5) rate = RATE_4_5;
    else if (rate > RATE_4_8) rate = RATE_4_8;
    // Header codewords always use the strongest rate.
    if (pos < hdr_len) rate = RATE_4_8;
    width = int'(rate) + 4;
    for (int k = 0; k < 4; k++) d[k] = cw[width - 1 - k];
    // Single-bit correction at 4/7, and at 4/8 only when total parity is odd.
    if (rate >= RATE_4_7 && (rate != RATE_4_8 || ^cw)) begin
      for (int k = 0; k < 3; k++) p[k] = cw[width - 5 - k];
      syn[0] = d[0] ^ d[1] ^ d[2] ^ p[0];
      syn[1] = d[1] ^ d[2] ^ d[3] ^ p[1];
      syn[2] = d[0] ^ d[1] ^ d[3] ^ p[2];
      case (syn)
        SYN_FLIP_D0: d[0] = ~d[0];
        SYN_FLIP_D1: d[1] = ~d[1];
        SYN_FLIP_D2: d[2] = ~d[2];
        SYN_FLIP_D3: d[3] = ~d[3];
        default: ;
      endcase
    end
    frame_pos = (pos < IDX_MAX) ? pos + 1'b1 : IDX_MAX;
    return d;
  endfunction

  // Offers one codeword after a random gap and records its expected nibble on transfer.
  task automatic send_codeword(input logic [CW_W-1:0] cw, input logic fs,
                               input int unsigned gap_max, input logic known,
                               input logic [NIB_W-1:0] known_nibble);
    int unsigned      gap;
    logic [NIB_W-1:0] predicted;
    gap = $urandom_range(0, gap_max);
    repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
    @(negedge clk) begin
      s_tvalid <= 1'b1;
      s_tdata  <= cw;
      s_tuser  <= fs;
    end
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = decode_codeword(cw, fs);
    if (known) predicted = known_nibble;
    expected_nibbles = {expected_nibbles, predicted};
  endtask

  // Lets the pipeline drain, then writes both registers.
  task automatic apply_settings(input decoder_settings_t settings);
    @(negedge clk) s_tvalid <= 1'b0;
    while (expected_nibbles.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    @(negedge clk) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_CODING_RATE;
      cfg_data  <= settings.rate;
    end
    @(negedge clk) begin
      cfg_index <= REG_SPREADING_FACTOR;
      cfg_data  <= settings.sf;
    end
    @(negedge clk) cfg_wr_en <= 1'b0;
    rate_cfg        = settings.rate[RATE_W-1:0];
    sf_cfg          = settings.sf;
    active_settings = settings;
  endtask

  // Stimulus: directed table, then random frames under each phase setting.
  initial begin
    int unsigned sent;
    int unsigned frame_len;
    int unsigned gap_max;
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_index       = REG_CODING_RATE;
    cfg_data        = '0;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    s_tuser         = 1'b0;
    rate_cfg        = CODING_RATE_RST;
    sf_cfg          = SPREADING_FACTOR_RST;
    frame_pos       = '0;
    active_settings = '{CFG_D_W'(CODING_RATE_RST), CFG_D_W'(SPREADING_FACTOR_RST)};
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].settings != active_settings)
        apply_settings(DIRECTED_ROWS[r].settings);
      send_codeword(DIRECTED_ROWS[r].cw, DIRECTED_ROWS[r].fs, 9,
                    DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].nibble);
    end

    // Mostly well-formed frames, some stray codewords with a random start flag.
    foreach (RANDOM_PHASES[ph]) begin
      apply_settings(RANDOM_PHASES[ph]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
        if ($urandom_range(0, 6) == 0) begin
          send_codeword(CW_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        gap_max, 1'b0, '0);
          sent++;
        end else begin
          frame_len = $urandom_range(1, 24);
          for (int k = 0; k < frame_len; k++)
            send_codeword(CW_W'($urandom_range(0, 255)), k == 0, gap_max, 1'b0, '0);
          sent += frame_len;
        end
      end
    end

    @(negedge clk) s_tvalid <= 1'b0;
    while (expected_nibbles.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, with quiet stretches where it is always ready.
  initial begin
    int unsigned stall;
    logic        busy_mode;
    busy_mode = 1'b1;
    m_tready  = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 19) == 0) busy_mode = ~busy_mode;
      stall = busy_mode ? $urandom_range(0, 9) : 0;
      repeat (stall) @(negedge clk) m_tready <= 1'b0;
      @(negedge clk) m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest expected nibble.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_nibbles.size() == 0) begin
        $error("nibble: no result expected, got %h", m_tdata[NIB_W-1:0]);
        mismatch_count++;
      end else begin
        want_nibble = expected_nibbles.pop_front();
        if (m_tdata[NIB_W-1:0] !== want_nibble) begin
          $error("nibble: expected %h, got %h", want_nibble, m_tdata[NIB_W-1:0]);
          mismatch_count++;
        end
        if (m_tdata[TDATA_W-1:NIB_W] !== '0) begin
          $error("tdata padding: expected %h, got %h", {(TDATA_W-NIB_W){1'b0}},
                 m_tdata[TDATA_W-1:NIB_W]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer on either stream.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    idle_cycles    = 0;
  end

endmodule

@@ filelist.f @@
sv/lhd_pkg.sv
sv/lhd_frame_ctrl.sv
sv/lhd_decode.sv
sv/lora_hamming_decoder.sv
dv/tb_top.sv
